/* sv/kabf_pkg.sv */
`timescale 1ns / 1ps
package kabf_pkg;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int COV_FRAC_BITS = 24;
	localparam int DT_FRAC_BITS = 16;
	localparam int REG_W = 32;
	localparam int DT_W = 16;
	localparam int DIV_STEPS = 32;

	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

	localparam logic [31:0] RST_ANGLE_NOISE = 32'd16777;
	localparam logic [31:0] RST_BIAS_NOISE = 32'd50332;
	localparam logic [31:0] RST_MEAS_NOISE = 32'd503316;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) sat32 = 32'h7fffffff;
		else if (v < lo) sat32 = 32'h80000000;
		else sat32 = v[31:0];
	endfunction
endpackage

/* sv/kalman_angle_bias_filter_core.sv */
`timescale 1ns / 1ps
// Two-state angle/gyro-bias Kalman filter. One request is accepted when the
// block is idle. Its result is valid after the prediction steps on the shared
// 32x32 multiplier, then two divider passes (a load with overflow check, then
// 32 restoring steps), one per gain, then the update steps on the multiplier.
// When S is not positive the correction is skipped and the result is valid
// straight after the prediction steps. in_ready stays low until the result
// has been taken. The next request can be accepted in the cycle after the
// result is taken.
// Config writes take effect at once and must only be done while idle.
module kalman_angle_bias_filter_core #(
	parameter int COV_FRAC_BITS = kabf_pkg::COV_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] accel_angle_in,
	input  logic signed [31:0] gyro_rate_in,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] unbiased_rate,
	output logic               correction_skipped
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam logic [31:0] ONE_COV = 32'd1 << COV_FRAC_BITS;
	localparam int DS = kabf_pkg::DT_FRAC_BITS;

	state_t state_q;
	logic [3:0] step_q;
	logic [5:0] dcnt_q;
	logic       dsel_q;
	logic [31:0] qa_q, qb_q, r_q;
	logic signed [31:0] ang_est_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] z_q, rate_q, ang_q, fp00_q, n01_q, n10_q, n00_q, n11_q;
	logic signed [31:0] innov_q, k0_q, k1_q, dt_q;
	logic skip_q;
	logic [32:0] s_q;
	// divider
	logic [31:0] dnum_q;
	logic [30:0] dquo_q;
	logic [32:0] drem_q;
	logic dneg_q;
	logic ovf_q;

	// shared multiplier
	logic signed [31:0] ma, mb;
	logic [5:0] msh;
	logic signed [63:0] mp;
	logic signed [65:0] mr;

	logic signed [33:0] s_sum;
	logic [33:0] dshift;
	logic [33:0] dtrial;
	logic [31:0] qn;
	logic signed [31:0] kval;
	logic [63:0] nabs;
	logic signed [63:0] nsh;

	always_comb begin
		ma = dt_q; mb = p10_q; msh = 6'(DS);
		case (step_q)
			4'd0: begin ma = rate_q; mb = dt_q; end
			4'd1: begin ma = dt_q; mb = p10_q; end
			4'd2: begin ma = dt_q; mb = p11_q; end
			4'd3: begin ma = dt_q; mb = n01_q; end
			4'd4: begin ma = k0_q; mb = innov_q; msh = 6'(COV_FRAC_BITS); end
			4'd5: begin ma = k1_q; mb = innov_q; msh = 6'(COV_FRAC_BITS); end
			4'd6: begin ma = k0_q; mb = n00_q; msh = 6'(COV_FRAC_BITS); end
			4'd7: begin ma = k0_q; mb = n01_q; msh = 6'(COV_FRAC_BITS); end
			4'd8: begin ma = k1_q; mb = n00_q; msh = 6'(COV_FRAC_BITS); end
			4'd9: begin ma = k1_q; mb = n01_q; msh = 6'(COV_FRAC_BITS); end
			default: ;
		endcase
		mp = ma * mb;
		mr = (66'(mp) + (66'sd1 <<< (msh - 6'd1))) >>> msh;
	end

	// S needs 34 bits: n00 can be near 2^31 and R near 2^32
	always_comb begin
		s_sum = 34'(n00_q) + $signed({2'b00, r_q});
		dshift = {drem_q, dnum_q[31]};
		dtrial = dshift - {1'b0, s_q};
		qn = {dquo_q, ~dtrial[33]};
		if (ovf_q) kval = dneg_q ? 32'sh80000000 : 32'sh7fffffff;
		else kval = dneg_q ? -$signed(qn) : $signed(qn);
	end

	always_comb begin
		nsh = 64'(dsel_q ? n10_q : n00_q) <<< COV_FRAC_BITS;
		nabs = nsh[63] ? 64'(-nsh) : 64'(nsh);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign filtered_angle = ang_est_q;
	assign unbiased_rate = rate_q;
	assign correction_skipped = skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0; dcnt_q <= '0; dsel_q <= 1'b0;
			qa_q <= kabf_pkg::RST_ANGLE_NOISE;
			qb_q <= kabf_pkg::RST_BIAS_NOISE;
			r_q <= kabf_pkg::RST_MEAS_NOISE;
			ang_est_q <= '0; bias_q <= '0;
			p00_q <= ONE_COV; p01_q <= '0; p10_q <= '0; p11_q <= ONE_COV;
			skip_q <= 1'b0;
			z_q <= '0; rate_q <= '0; ang_q <= '0; fp00_q <= '0;
			n01_q <= '0; n10_q <= '0; n00_q <= '0; n11_q <= '0;
			innov_q <= '0; k0_q <= '0; k1_q <= '0; dt_q <= '0;
			s_q <= '0; dnum_q <= '0; dquo_q <= '0; drem_q <= '0;
			dneg_q <= 1'b0; ovf_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kabf_pkg::REG_ANGLE_NOISE: qa_q <= cfg_data;
					kabf_pkg::REG_BIAS_NOISE: qb_q <= cfg_data;
					kabf_pkg::REG_MEAS_NOISE: r_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						z_q <= accel_angle_in;
						dt_q <= 32'($unsigned(time_step));
						rate_q <= kabf_pkg::sat32(66'(gyro_rate_in) - 66'(bias_q));
						step_q <= 4'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q != 4'd4) step_q <= step_q + 4'd1;
					case (step_q)
						4'd0: ang_q <= kabf_pkg::sat32(66'(ang_est_q) + mr);
						4'd1: fp00_q <= kabf_pkg::sat32(66'(p00_q) - mr);
						4'd2: begin
							n01_q <= kabf_pkg::sat32(66'(p01_q) - mr);
							n10_q <= kabf_pkg::sat32(66'(p10_q) - mr);
							n11_q <= kabf_pkg::sat32(66'(p11_q) + 66'(qb_q));
						end
						4'd3: begin
							n00_q <= kabf_pkg::sat32(66'(fp00_q) - mr + 66'(qa_q));
							innov_q <= kabf_pkg::sat32(66'(z_q) - 66'(ang_q));
						end
						4'd4: begin
							s_q <= s_sum[32:0];
							if (s_sum <= 0) begin
								skip_q <= 1'b1;
								ang_est_q <= ang_q;
								p00_q <= n00_q; p01_q <= n01_q;
								p10_q <= n10_q; p11_q <= n11_q;
								state_q <= ST_OUT;
							end else begin
								skip_q <= 1'b0;
								dsel_q <= 1'b0;
								state_q <= ST_DIV;
								dcnt_q <= 6'd0;
							end
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (dcnt_q == 6'd0) begin
						// quotient reaches 2^31 exactly when |N| >> 31 >= S
						ovf_q <= (nabs[63:31] >= s_q);
						drem_q <= {1'b0, nabs[63:32]};
						dnum_q <= nabs[31:0];
						dneg_q <= nsh[63];
						dquo_q <= '0;
						dcnt_q <= 6'd1;
					end else begin
						dnum_q <= {dnum_q[30:0], 1'b0};
						drem_q <= dtrial[33] ? dshift[32:0] : dtrial[32:0];
						dquo_q <= qn[30:0];
						if (dcnt_q == 6'(kabf_pkg::DIV_STEPS)) begin
							dcnt_q <= 6'd0;
							if (!dsel_q) begin
								k0_q <= kval;
								dsel_q <= 1'b1;
							end else begin
								k1_q <= kval;
								step_q <= 4'd4;
								state_q <= ST_UPD;
							end
						end else begin
							dcnt_q <= dcnt_q + 6'd1;
						end
					end
				end
				ST_UPD: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd4: ang_est_q <= kabf_pkg::sat32(66'(ang_q) + mr);
						4'd5: bias_q <= kabf_pkg::sat32(66'(bias_q) + mr);
						4'd6: p00_q <= kabf_pkg::sat32(66'(n00_q) - mr);
						4'd7: p01_q <= kabf_pkg::sat32(66'(n01_q) - mr);
						4'd8: p10_q <= kabf_pkg::sat32(66'(n10_q) - mr);
						4'd9: begin
							p11_q <= kabf_pkg::sat32(66'(n11_q) - mr);
							state_q <= ST_OUT;
						end
						default: ;
					endcase
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("busy overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(filtered_angle)))
		else $error("result changed while stalled");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL)) else $error("no start");
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1630;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic               skipped;
	} kf_result_t;

	typedef struct {
		logic signed [31:0] z;
		logic signed [31:0] g;
		logic [15:0]        dt;
		logic               known;
		kf_result_t         res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] accel_angle_in;
	logic signed [31:0] gyro_rate_in;
	logic [15:0] time_step;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] unbiased_rate;
	logic correction_skipped;

	kalman_angle_bias_filter_core i_dut (.*);

	// filter state mirror
	logic [31:0] q_angle, q_bias, r_meas;
	longint est_angle, est_bias;
	longint cov [4];

	kf_result_t pending_results[$];
	int errors;
	int idle_cycles;
	bit stall_mode;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product rescaled by 2^-s, round half up (>>> floors)
	function automatic longint scaled_mul(longint a, longint b, int s);
		longint p;
		p = a * b + (64'sd1 <<< (s - 1));
		return p >>> s;
	endfunction

	function automatic kf_result_t kalman_step(longint z, longint g, longint dt);
		longint p00, p01, p10, p11, rate, ang, fp00, fp01, n00, n01, n10, n11;
		longint innov, s, k0, k1;
		kf_result_t r;
		p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
		rate = clamp32(g - est_bias);
		ang = clamp32(est_angle + scaled_mul(rate, dt, kabf_pkg::DT_FRAC_BITS));
		fp00 = clamp32(p00 - scaled_mul(dt, p10, kabf_pkg::DT_FRAC_BITS));
		fp01 = clamp32(p01 - scaled_mul(dt, p11, kabf_pkg::DT_FRAC_BITS));
		n00 = clamp32(fp00 - scaled_mul(dt, fp01, kabf_pkg::DT_FRAC_BITS)
			+ longint'(q_angle));
		n01 = fp01;
		n10 = clamp32(p10 - scaled_mul(dt, p11, kabf_pkg::DT_FRAC_BITS));
		n11 = clamp32(p11 + longint'(q_bias));
		innov = clamp32(z - ang);
		s = n00 + longint'(r_meas);
		r.skipped = (s <= 0);
		if (s <= 0) begin
			est_angle = ang;
			cov[0] = n00; cov[1] = n01; cov[2] = n10; cov[3] = n11;
		end else begin
			k0 = clamp32((n00 * (64'sd1 <<< kabf_pkg::COV_FRAC_BITS)) / s);
			k1 = clamp32((n10 * (64'sd1 <<< kabf_pkg::COV_FRAC_BITS)) / s);
			est_angle = clamp32(ang + scaled_mul(k0, innov, kabf_pkg::COV_FRAC_BITS));
			est_bias = clamp32(est_bias + scaled_mul(k1, innov, kabf_pkg::COV_FRAC_BITS));
			cov[0] = clamp32(n00 - scaled_mul(k0, n00, kabf_pkg::COV_FRAC_BITS));
			cov[1] = clamp32(n01 - scaled_mul(k0, n01, kabf_pkg::COV_FRAC_BITS));
			cov[2] = clamp32(n10 - scaled_mul(k1, n00, kabf_pkg::COV_FRAC_BITS));
			cov[3] = clamp32(n11 - scaled_mul(k1, n01, kabf_pkg::COV_FRAC_BITS));
		end
		r.angle = est_angle[31:0];
		r.rate = rate[31:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stalls in runs, switching pattern now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= ~stall_mode;
			out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		kf_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result angle=%0d", filtered_angle);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (filtered_angle !== exp_res.angle) begin
					$error("filtered_angle exp %0d got %0d", exp_res.angle, filtered_angle);
					errors++;
				end
				if (unbiased_rate !== exp_res.rate) begin
					$error("unbiased_rate exp %0d got %0d", exp_res.rate, unbiased_rate);
					errors++;
				end
				if (correction_skipped !== exp_res.skipped) begin
					$error("correction_skipped exp %0b got %0b", exp_res.skipped,
						correction_skipped);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == kabf_pkg::REG_ANGLE_NOISE) q_angle = val;
		else if (idx == kabf_pkg::REG_BIAS_NOISE) q_bias = val;
		else if (idx == kabf_pkg::REG_MEAS_NOISE) r_meas = val;
	endtask

	task automatic drain_filter();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [31:0] z, input logic signed [31:0] g,
			input logic [15:0] dt, input bit known, input kf_result_t res);
		kf_result_t pred;
		in_valid <= 1'b1;
		accel_angle_in <= z;
		gyro_rate_in <= g;
		time_step <= dt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = kalman_step(z, g, dt);
		if (known && pred !== res) begin
			$error("directed row prediction exp %h got %h", res, pred);
			errors++;
		end
		pending_results.push_back(pred);
	endtask

	task automatic pace_sender(inout int burst);
		if (burst > 0) begin
			burst--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
			burst = $urandom_range(0, 12);
		end
	endtask

	function automatic logic signed [31:0] rand_angle(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 'h00B40000)) - 32'sh005A0000;
			default: return $signed($urandom_range(0, 'h0000FFFF)) - 32'sh00008000;
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		kf_result_t r0;
		int burst;
		int phase;
		logic [15:0] dt;
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kabf_pkg::REG_ANGLE_NOISE;
		cfg_data = '0;
		in_valid = 1'b0;
		accel_angle_in = '0;
		gyro_rate_in = '0;
		time_step = '0;
		q_angle = kabf_pkg::RST_ANGLE_NOISE;
		q_bias = kabf_pkg::RST_BIAS_NOISE;
		r_meas = kabf_pkg::RST_MEAS_NOISE;
		est_angle = 0;
		est_bias = 0;
		cov[0] = 64'sd1 <<< kabf_pkg::COV_FRAC_BITS;
		cov[1] = 0;
		cov[2] = 0;
		cov[3] = 64'sd1 <<< kabf_pkg::COV_FRAC_BITS;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset, zero inputs give zero angle and zero rate
		r0 = '{angle: 32'sd0, rate: 32'sd0, skipped: 1'b0};
		row = '{z: 0, g: 0, dt: 0, known: 1, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh7fffffff, g: 32'sh7fffffff, dt: 16'hffff, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh80000000, g: 32'sh80000000, dt: 16'hffff, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh80000000, g: 32'sh7fffffff, dt: 16'h0001, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh7fffffff, g: 32'sh80000000, dt: 16'h8000, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh000a0000, g: 32'shfffb0000, dt: 16'h0041, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'sh55555555, g: 32'shaaaaaaaa, dt: 16'h5555, known: 0, res: r0};
		rows.push_back(row);
		row = '{z: 32'shaaaaaaaa, g: 32'sh55555555, dt: 16'haaaa, known: 0, res: r0};
		rows.push_back(row);
		foreach (rows[i])
			send_sample(rows[i].z, rows[i].g, rows[i].dt, rows[i].known, rows[i].res);
		in_valid <= 1'b0;
		drain_filter();

		// noise extremes: zero everywhere, then all-ones, plus an ignored index
		write_reg(kabf_pkg::REG_ANGLE_NOISE, 32'd0);
		write_reg(kabf_pkg::REG_BIAS_NOISE, 32'd0);
		write_reg(kabf_pkg::REG_MEAS_NOISE, 32'd0);
		write_reg(2'd3, 32'hdeadbeef);
		for (int i = 0; i < 6; i++) begin
			send_sample(rand_angle(i % 3), rand_angle(2), 16'(i * 'h2aaa), 0, r0);
		end
		in_valid <= 1'b0;
		drain_filter();
		write_reg(kabf_pkg::REG_ANGLE_NOISE, 32'hffffffff);
		write_reg(kabf_pkg::REG_BIAS_NOISE, 32'hffffffff);
		write_reg(kabf_pkg::REG_MEAS_NOISE, 32'hffffffff);
		for (int i = 0; i < 6; i++) begin
			send_sample(rand_angle(0), rand_angle(0), 16'($urandom()), 0, r0);
		end
		in_valid <= 1'b0;
		drain_filter();

		// random phases; each phase starts with new noise settings (phase 4 keeps the bias noise)
		burst = 0;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(kabf_pkg::REG_ANGLE_NOISE, kabf_pkg::RST_ANGLE_NOISE);
					write_reg(kabf_pkg::REG_BIAS_NOISE, kabf_pkg::RST_BIAS_NOISE);
					write_reg(kabf_pkg::REG_MEAS_NOISE, kabf_pkg::RST_MEAS_NOISE);
				end
				4: begin
					// angle noise near 2^31 drives the predicted covariance into saturation
					write_reg(kabf_pkg::REG_ANGLE_NOISE,
						32'h80000000 + $urandom_range(0, 1000));
					write_reg(kabf_pkg::REG_MEAS_NOISE, $urandom_range(0, 255));
				end
				default: begin
					write_reg(kabf_pkg::REG_ANGLE_NOISE, $urandom());
					write_reg(kabf_pkg::REG_BIAS_NOISE, $urandom_range(0, 1 << (8 * phase)));
					write_reg(kabf_pkg::REG_MEAS_NOISE, $urandom_range(0, 1 << (8 * phase)));
				end
			endcase
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				case ($urandom_range(0, 9))
					0: dt = 16'($urandom());
					1: dt = 16'd0;
					2: dt = 16'hffff;
					default: dt = 16'($urandom_range(1, 1000));
				endcase
				send_sample(rand_angle(($urandom_range(0, 9) == 0) ? 0 : 1),
					rand_angle(($urandom_range(0, 9) == 0) ? 0 : 2), dt, 0, r0);
				pace_sender(burst);
			end
			in_valid <= 1'b0;
			drain_filter();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
